// ===== design/dssg_pkg.sv =====
`timescale 1ns / 1ps

package dssg_pkg;

  // Request opcodes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Output modes; the unused code behaves as real cosine only.
  localparam logic [1:0] MODE_COMPLEX = 2'd0;
  localparam logic [1:0] MODE_SEQ     = 2'd1;
  localparam logic [1:0] MODE_REAL    = 2'd2;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_ACTIVE_LINES = 2'd0;
  localparam logic [1:0] REG_OUTPUT_MODE  = 2'd1;
  localparam logic [1:0] REG_GLOBAL_PHASE = 2'd2;

  // CORDIC datapath.
  localparam int CORDIC_STAGES = 24;
  localparam int XW            = 34;
  localparam int ZW            = 34;
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One term amp * trig * env / 2^30 always fits in this many signed bits.
  localparam int TERM_W = 35;

  typedef struct packed {
    logic               func;
    logic [3:0]         line_index;
    logic signed [15:0] line_amplitude;
    logic [31:0]        start_phase;
    logic [31:0]        phase_step;
    logic [31:0]        start_envelope;
    logic [31:0]        decay_factor;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sample_real;
    logic signed [31:0] sample_imag;
    logic               is_imag_slot;
    logic               saturated;
  } res_t;

  // One spectral line as it sits in the line memory.
  typedef struct packed {
    logic signed [15:0] amp;
    logic [31:0]        phase;
    logic [31:0]        step;
    logic [31:0]        env;
    logic [31:0]        decay;
  } line_t;

  // Side data that travels with an angle through the trig pipeline.
  typedef struct packed {
    logic               last;
    logic signed [15:0] amp;
    logic [31:0]        env;
  } trig_tag_t;

  // Per-tick control from the sequencer to the accumulator.
  typedef struct packed {
    logic       clear;
    logic       empty;
    logic [1:0] mode;
  } tick_ctrl_t;

endpackage

// ===== design/dssg_ram.sv =====
`timescale 1ns / 1ps

module dssg_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dssg_cordic.sv =====
`timescale 1ns / 1ps

module dssg_cordic (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [31:0]               angle,
  input  dssg_pkg::trig_tag_t       in_tag,
  output logic                      out_valid,
  output logic signed [15:0]        cos_v,
  output logic signed [15:0]        sin_v,
  output dssg_pkg::trig_tag_t       out_tag
);
  import dssg_pkg::*;

  logic                v_q    [CORDIC_STAGES+1];
  logic                flip_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_q   [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_q   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q   [CORDIC_STAGES+1];
  trig_tag_t           tag_q  [CORDIC_STAGES+1];

  logic        flip_in;
  logic [31:0] q_in;

  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v,
                                                input logic neg);
    logic signed [XW-1:0] r;
    logic signed [15:0]   c;
    r = (v + $signed(XW'(16384))) >>> 15;
    if (r > $signed(XW'(32767))) begin
      c = 16'sd32767;
    end else if (r < -$signed(XW'(32767))) begin
      c = -16'sd32767;
    end else begin
      c = r[15:0];
    end
    if (neg) begin
      c = -c;
    end
    return c;
  endfunction

  // Fold the left half plane onto the right one and undo it at the end.
  always_comb begin
    flip_in = 1'(((angle + 32'h4000_0000) >> 31));
    q_in    = {angle[31] ^ flip_in, angle[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    flip_q[0] <= flip_in;
    x_q[0]    <= $signed({{(XW-32){1'b0}}, CORDIC_X0});
    y_q[0]    <= '0;
    z_q[0]    <= $signed({{(ZW-32){q_in[31]}}, q_in});
    tag_q[0]  <= in_tag;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [ZW-1:0] atan_k;
    assign atan_k = $signed({{(ZW-32){1'b0}}, ATAN_TURNS[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
      flip_q[k+1] <= flip_q[k];
      tag_q[k+1]  <= tag_q[k];
      if (!z_q[k][ZW-1]) begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - atan_k;
      end else begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + atan_k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_q[CORDIC_STAGES];
    end
    cos_v   <= to_q15(x_q[CORDIC_STAGES], flip_q[CORDIC_STAGES]);
    sin_v   <= to_q15(y_q[CORDIC_STAGES], flip_q[CORDIC_STAGES]);
    out_tag <= tag_q[CORDIC_STAGES];
  end

endmodule

// ===== design/dssg_acc.sv =====
`timescale 1ns / 1ps

module dssg_acc #(
  parameter int SUM_W = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dssg_pkg::tick_ctrl_t ctrl,
  input  logic                 term_valid,
  input  logic signed [15:0]   cos_v,
  input  logic signed [15:0]   sin_v,
  input  dssg_pkg::trig_tag_t  tag,
  output dssg_pkg::res_t       result,
  output logic                 result_valid
);
  import dssg_pkg::*;

  // First multiply stage: amplitude times trig value.
  logic               m1_valid;
  logic               m1_last;
  logic [31:0]        m1_env;
  logic signed [31:0] m1_c;
  logic signed [31:0] m1_s;

  // Second multiply stage: times envelope, floored by 2^30.
  logic                   m2_valid;
  logic                   m2_last;
  logic signed [TERM_W-1:0] t_c;
  logic signed [TERM_W-1:0] t_s;
  logic signed [64:0]       prod_c;
  logic signed [64:0]       prod_s;

  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] sum_s;
  logic                    fin;
  logic                    seq_slot;

  logic signed [SUM_W:0] ext_c;
  logic signed [SUM_W:0] neg_s;
  logic signed [SUM_W:0] ext_s;
  logic signed [31:0]    sat_c;
  logic signed [31:0]    sat_s;
  logic signed [31:0]    sat_ns;
  logic                  clip_c;
  logic                  clip_s;
  logic                  clip_ns;
  res_t                  res_next;

  function automatic logic signed [31:0] clip32(input logic signed [SUM_W:0] v);
    logic signed [31:0] r;
    if (v > $signed(33'h0_7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed(33'h1_8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic clipped(input logic signed [SUM_W:0] v);
    return (v > $signed(33'h0_7FFF_FFFF)) || (v < $signed(33'h1_8000_0000));
  endfunction

  always_comb begin
    prod_c = 65'(m1_c) * 65'($signed({1'b0, m1_env}));
    prod_s = 65'(m1_s) * 65'($signed({1'b0, m1_env}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= term_valid;
      m2_valid <= m1_valid;
    end
    m1_last <= tag.last;
    m1_env  <= tag.env;
    m1_c    <= 32'(tag.amp) * 32'(cos_v);
    m1_s    <= 32'(tag.amp) * 32'(sin_v);
    m2_last <= m1_last;
    t_c     <= prod_c[30 +: TERM_W];
    t_s     <= prod_s[30 +: TERM_W];
  end

  // The sums are final once the last term is added in; fin is registered alongside that addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= (m2_valid && m2_last) || ctrl.empty;
    end
    if (ctrl.clear) begin
      sum_c <= '0;
      sum_s <= '0;
    end else if (m2_valid) begin
      sum_c <= sum_c + {{(SUM_W-TERM_W){t_c[TERM_W-1]}}, t_c};
      sum_s <= sum_s + {{(SUM_W-TERM_W){t_s[TERM_W-1]}}, t_s};
    end
  end

  always_comb begin
    ext_c   = {sum_c[SUM_W-1], sum_c};
    ext_s   = {sum_s[SUM_W-1], sum_s};
    neg_s   = -ext_s;
    sat_c   = clip32(ext_c);
    sat_s   = clip32(ext_s);
    sat_ns  = clip32(neg_s);
    clip_c  = clipped(ext_c);
    clip_s  = clipped(ext_s);
    clip_ns = clipped(neg_s);

    res_next = '0;
    unique case (ctrl.mode)
      MODE_COMPLEX: begin
        res_next.sample_real = sat_c;
        res_next.sample_imag = sat_s;
        res_next.saturated   = clip_c | clip_s;
      end
      MODE_SEQ: begin
        res_next.is_imag_slot = seq_slot;
        res_next.sample_real  = seq_slot ? sat_ns : sat_c;
        res_next.saturated    = seq_slot ? clip_ns : clip_c;
      end
      default: begin
        res_next.sample_real = sat_c;
        res_next.saturated   = clip_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      seq_slot     <= 1'b0;
    end else begin
      result_valid <= fin;
      if (fin && ctrl.mode == MODE_SEQ) begin
        seq_slot <= ~seq_slot;
      end
    end
    result <= res_next;
  end

endmodule

// ===== design/damped_sinusoid_sum_generator_core.sv =====
`timescale 1ns / 1ps

// Damped sinusoid sum generator: builds a decaying multi-line signal sample by sample.
// Requests enter on start/busy: a request is taken at an edge where start is high
// and busy is low. A load request writes one line into the line memory in that
// cycle and produces no result; busy stays low, so loads can follow each other
// every cycle. A tick request walks lines 0 to n_lines-1 (active_lines capped at
// MAX_LINES) through the line memory, one read per cycle. Each line goes through a
// 26-stage pipelined CORDIC and two multiply stages into the sums, and is written
// back from the write-back register, advanced by one dwell. The result strobe
// result_valid comes once the last line's terms are summed (or from the tick itself
// when no lines are active), and busy falls the cycle after it, so a new tick is
// taken only after the previous result. The strobe lasts one cycle; the receiver
// cannot stall, so a result is never held. Registers (active_lines, output_mode,
// global_phase) sit on the APB port at 0, 4 and 8; the user must write them only
// while the block is idle, since the block itself does not enforce this. Reset
// clears the registers, the sequential-mode slot and all control state; line memory
// contents are left as they are and must be loaded before a tick uses them.
module damped_sinusoid_sum_generator_core #(
  parameter int MAX_LINES       = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dssg_pkg::req_t  request,
  output logic            result_valid,
  output dssg_pkg::res_t  result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import dssg_pkg::*;

  localparam int AW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW    = $clog2(MAX_LINES + 1);
  localparam int SUM_W = TERM_W + CW;
  localparam int LW    = $bits(line_t);
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [4:0]  active_lines;
  logic [1:0]  output_mode;
  logic [31:0] global_phase;

  logic [CW-1:0] n_lines;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;
  logic          accept;
  logic          tick_go;
  logic          issue;
  logic          issue_last;

  // Read side of the line memory.
  logic          rd_valid;
  logic          rd_last;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] rd_data;
  line_t         rd_line;

  // Write-back stage.
  line_t         adv_line;
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  line_t         wb_line;
  logic [63:0]   wb_prod;
  line_t         wb_out;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  line_t         mem_wdata;
  line_t         load_line;
  logic          load_ok;

  logic         trig_valid;
  logic signed [15:0] trig_cos;
  logic signed [15:0] trig_sin;
  trig_tag_t    trig_tag;
  trig_tag_t    cordic_tag;
  logic [31:0]  cordic_angle;
  tick_ctrl_t   ctrl;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lines <= '0;
      output_mode  <= MODE_COMPLEX;
      global_phase <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ACTIVE_LINES: active_lines <= pwdata[4:0];
        REG_OUTPUT_MODE:  output_mode  <= pwdata[1:0];
        REG_GLOBAL_PHASE: global_phase <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE_LINES: prdata = {27'd0, active_lines};
      REG_OUTPUT_MODE:  prdata = {30'd0, output_mode};
      REG_GLOBAL_PHASE: prdata = global_phase;
      default:          prdata = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    if (32'(active_lines) > 32'(MAX_LINES)) begin
      n_lines = CW'(MAX_LINES);
    end else begin
      n_lines = CW'(active_lines);
    end
  end

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign tick_go    = accept && (request.func == FUNC_TICK);
  assign issue      = (state == ST_ISSUE);
  assign issue_last = (CW'(cnt) + CW'(1)) == n_lines;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (tick_go) begin
          state_next = (n_lines == '0) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cnt_next = cnt + AW'(1);
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (result_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      rd_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_valid <= issue;
      wb_valid <= rd_valid;
    end
    rd_last <= issue_last;
    rd_addr <= cnt;
  end

  // Line memory: reads one line per cycle during a tick, writes loads while
  // idle and write-backs while busy.
  assign load_ok = 32'(request.line_index) < 32'(MAX_LINES);

  always_comb begin
    load_line.amp   = request.line_amplitude;
    load_line.phase = request.start_phase;
    load_line.step  = request.phase_step;
    load_line.env   = request.start_envelope;
    load_line.decay = request.decay_factor;
  end

  always_comb begin
    wb_out     = wb_line;
    wb_out.env = wb_prod[63] ? 32'hFFFF_FFFF : wb_prod[62:31];
  end

  always_comb begin
    if (busy) begin
      mem_we    = wb_valid;
      mem_waddr = wb_addr;
      mem_wdata = wb_out;
    end else begin
      mem_we    = accept && (request.func == FUNC_LOAD) && load_ok;
      mem_waddr = AW'(request.line_index);
      mem_wdata = load_line;
    end
  end

  dssg_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_LINES),
    .AW    (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (cnt),
    .rdata (rd_data)
  );

  assign rd_line = line_t'(rd_data);

  always_comb begin
    adv_line       = rd_line;
    adv_line.phase = rd_line.phase + rd_line.step;
  end

  // Advance phase and envelope by one dwell; the old envelope rides with the angle.
  always_ff @(posedge clk) begin
    wb_addr <= rd_addr;
    wb_line <= adv_line;
    wb_prod <= 64'(rd_line.env) * 64'(rd_line.decay);
  end

  always_comb begin
    cordic_angle   = (rd_line.phase + global_phase) & ANGLE_MASK;
    cordic_tag.last = rd_last;
    cordic_tag.amp  = rd_line.amp;
    cordic_tag.env  = rd_line.env;
  end

  dssg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .angle     (cordic_angle),
    .in_tag    (cordic_tag),
    .out_valid (trig_valid),
    .cos_v     (trig_cos),
    .sin_v     (trig_sin),
    .out_tag   (trig_tag)
  );

  always_comb begin
    ctrl.clear = tick_go;
    ctrl.empty = tick_go && (n_lines == '0);
    ctrl.mode  = output_mode;
  end

  dssg_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .term_valid   (trig_valid),
    .cos_v        (trig_cos),
    .sin_v        (trig_sin),
    .tag          (trig_tag),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dssg_pkg::*;

  localparam int LINE_COUNT      = 16;
  localparam int TRIG_BITS       = 10;
  localparam int ROTATIONS       = 24;
  localparam longint GAIN_START  = 64'sd652032874;
  localparam longint SAMPLE_MAX  = 64'sd2147483647;
  localparam longint SAMPLE_MIN  = -64'sd2147483648;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] MODE_ORDER [4] = '{MODE_COMPLEX, MODE_SEQ, MODE_REAL, MODE_SPARE};
  localparam int RAND_PHASES     = 20;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int LOAD_SETTLE     = 4;
  localparam int TAIL_CYCLES     = 64;
  // Slowest request is a 16-line tick after the longest random gap;
  // about 2000 of them stay far below this.
  localparam int CYCLE_LIMIT     = 600000;

  localparam int ARCTAN_TURNS [ROTATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    req_t        req;
    logic        typed;
    res_t        known;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        result_valid;
  res_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the line memory and registers.
  logic signed [15:0] line_amp   [LINE_COUNT];
  logic [31:0]        line_phase [LINE_COUNT];
  logic [31:0]        line_step  [LINE_COUNT];
  logic [31:0]        line_env   [LINE_COUNT];
  logic [31:0]        line_decay [LINE_COUNT];
  logic               seq_slot = 1'b0;
  logic [4:0]         cfg_active = '0;
  logic [1:0]         cfg_mode = MODE_COMPLEX;
  logic [31:0]        cfg_gphase = '0;

  res_t pending_samples [$];
  res_t oldest;
  int   fault_count = 0;
  logic burst_mode = 1'b0;

  always #5 clk = ~clk;

  damped_sinusoid_sum_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  function automatic int round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    else if (r < -32767) r = -32767;
    return int'(r);
  endfunction

  // The angle is cut to the table resolution, folded into the right half
  // plane and rotated; the fold is undone by negating both outputs.
  function automatic void line_trig(input logic [31:0] angle, output int cos_q15,
                                    output int sin_q15);
    logic [31:0] q, quarter;
    logic        flip;
    longint      x, y, z, dx, dy;
    q = (angle >> (32 - TRIG_BITS)) << (32 - TRIG_BITS);
    quarter = q + 32'h4000_0000;
    flip = quarter[31];
    if (flip) q = q + 32'h8000_0000;
    z = longint'($signed(q));
    x = GAIN_START;
    y = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x = x - dy;
        y = y + dx;
        z = z - ARCTAN_TURNS[i];
      end else begin
        x = x + dy;
        y = y - dx;
        z = z + ARCTAN_TURNS[i];
      end
    end
    cos_q15 = round_q15(x);
    sin_q15 = round_q15(y);
    if (flip) begin
      cos_q15 = -cos_q15;
      sin_q15 = -sin_q15;
    end
  endfunction

  function automatic logic [31:0] clip32(input longint v, inout logic clipped);
    if (v > SAMPLE_MAX) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < SAMPLE_MIN) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void store_line(input req_t r);
    line_amp[r.line_index]   = r.line_amplitude;
    line_phase[r.line_index] = r.start_phase;
    line_step[r.line_index]  = r.phase_step;
    line_env[r.line_index]   = r.start_envelope;
    line_decay[r.line_index] = r.decay_factor;
  endfunction

  // Sums the active lines, advances them by one dwell and forms the sample.
  function automatic res_t synth_sample();
    res_t        r;
    int          n, c, s;
    longint      sum_c, sum_s;
    logic [31:0] angle;
    logic [63:0] env_next;
    logic        clipped;
    n = (cfg_active > LINE_COUNT) ? LINE_COUNT : int'(cfg_active);
    sum_c = 0;
    sum_s = 0;
    for (int i = 0; i < n; i++) begin
      angle = line_phase[i] + cfg_gphase;
      line_trig(angle, c, s);
      sum_c += (longint'(line_amp[i]) * c * longint'(line_env[i])) >>> 30;
      sum_s += (longint'(line_amp[i]) * s * longint'(line_env[i])) >>> 30;
      line_phase[i] = line_phase[i] + line_step[i];
      env_next = (64'(line_env[i]) * 64'(line_decay[i])) >> 31;
      line_env[i] = (env_next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : env_next[31:0];
    end
    r = '0;
    clipped = 1'b0;
    case (cfg_mode)
      MODE_COMPLEX: begin
        r.sample_real = clip32(sum_c, clipped);
        r.sample_imag = clip32(sum_s, clipped);
      end
      MODE_SEQ: begin
        r.is_imag_slot = seq_slot;
        if (seq_slot) r.sample_real = clip32(-sum_s, clipped);
        else r.sample_real = clip32(sum_c, clipped);
        seq_slot = ~seq_slot;
      end
      default: begin
        r.sample_real = clip32(sum_c, clipped);
      end
    endcase
    r.saturated = clipped;
    return r;
  endfunction

  // Mostly slowly decaying lines at most one in envelope, with some raw values.
  function automatic req_t random_load();
    req_t r;
    r.func = FUNC_LOAD;
    r.line_index = 4'($urandom_range(0, LINE_COUNT - 1));
    case ($urandom_range(0, 7))
      0: r.line_amplitude = 16'sh7FFF;
      1: r.line_amplitude = 16'sh8000;
      default: r.line_amplitude = 16'($urandom());
    endcase
    r.start_phase = $urandom();
    r.phase_step = $urandom_range(0, 1) ? $urandom_range(0, 32'h0100_0000) : $urandom();
    case ($urandom_range(0, 7))
      0: r.start_envelope = '0;
      1: r.start_envelope = $urandom();
      default: r.start_envelope = $urandom_range(0, 32'h8000_0000);
    endcase
    case ($urandom_range(0, 7))
      0: r.decay_factor = $urandom();
      1: r.decay_factor = 32'h8000_0000;
      default: r.decay_factor = $urandom_range(32'h7E00_0000, 32'h8000_0000);
    endcase
    return r;
  endfunction

  function automatic step_row_t row_cfg(input logic [1:0] idx, input logic [31:0] value);
    step_row_t w;
    w = '0;
    w.kind = ROW_CFG;
    w.reg_idx = idx;
    w.value = value;
    return w;
  endfunction

  function automatic step_row_t row_load(input logic [3:0] index, input logic [15:0] amp,
                                         input logic [31:0] phase, phase_inc, env, decay);
    step_row_t w;
    w = '0;
    w.kind = ROW_REQ;
    w.req.func = FUNC_LOAD;
    w.req.line_index = index;
    w.req.line_amplitude = amp;
    w.req.start_phase = phase;
    w.req.phase_step = phase_inc;
    w.req.start_envelope = env;
    w.req.decay_factor = decay;
    return w;
  endfunction

  function automatic step_row_t row_tick();
    step_row_t w;
    w = '0;
    w.kind = ROW_REQ;
    w.req = random_load();
    w.req.func = FUNC_TICK;
    return w;
  endfunction

  function automatic step_row_t row_known(input logic [31:0] re, im, input logic slot, sat);
    step_row_t w;
    w = row_tick();
    w.typed = 1'b1;
    w.known.sample_real = re;
    w.known.sample_imag = im;
    w.known.is_imag_slot = slot;
    w.known.saturated = sat;
    return w;
  endfunction

  // Must be called in the step where the previous request was taken, so that
  // start is either lowered or handed the next request at that very edge.
  task automatic send_request(input req_t r, input logic typed, input res_t known);
    int   gap;
    res_t sample;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.func == FUNC_TICK) begin
      sample = synth_sample();
      if (typed) sample = known;
      pending_samples = {pending_samples, sample};
    end else begin
      store_line(r);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_samples.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE_LINES: cfg_active = value[4:0];
      REG_OUTPUT_MODE:  cfg_mode = value[1:0];
      REG_GLOBAL_PHASE: cfg_gphase = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic note_fault(input string what, input logic [31:0] want, got);
    fault_count++;
    $display("%0t ns %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_samples.size() == 0) begin
        note_fault("sample with no tick waiting", 32'h0, result.sample_real);
      end else begin
        oldest = pending_samples.pop_front();
        if (result.sample_real !== oldest.sample_real)
          note_fault("sample_real", oldest.sample_real, result.sample_real);
        if (result.sample_imag !== oldest.sample_imag)
          note_fault("sample_imag", oldest.sample_imag, result.sample_imag);
        if (result.is_imag_slot !== oldest.is_imag_slot)
          note_fault("is_imag_slot", 32'(oldest.is_imag_slot), 32'(result.is_imag_slot));
        if (result.saturated !== oldest.saturated)
          note_fault("saturated", 32'(oldest.saturated), 32'(result.saturated));
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    step_row_t   plan [$];
    req_t        r;
    logic [4:0]  lines_pick;
    logic [31:0] gphase_pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every line is written once up front, so no tick can read an empty entry.
    for (int i = 0; i < LINE_COUNT; i++) begin
      r = random_load();
      r.line_index = 4'(i);
      send_request(r, 1'b0, '0);
    end

    plan = {plan, row_known(32'h0, 32'h0, 1'b0, 1'b0)};
    plan = {plan, row_cfg(REG_OUTPUT_MODE, {30'd0, MODE_REAL})};
    plan = {plan, row_cfg(REG_ACTIVE_LINES, 32'd2)};
    // Envelopes of one and above: two full-scale lines clip the sum both ways.
    plan = {plan, row_load(4'd0, 16'sh7FFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000)};
    plan = {plan, row_load(4'd1, 16'sh7FFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000)};
    plan = {plan, row_known(32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1)};
    plan = {plan, row_load(4'd0, 16'sh8000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
    plan = {plan, row_load(4'd1, 16'sh8000, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h8000_0000)};
    plan = {plan, row_known(32'h8000_0000, 32'h0, 1'b0, 1'b1)};
    plan = {plan, row_tick()};
    // The spare mode code behaves as real only; silent lines give exact zero.
    plan = {plan, row_cfg(REG_OUTPUT_MODE, {30'd0, MODE_SPARE})};
    plan = {plan, row_load(4'd0, 16'sh7FFF, 32'h1234_5678, 32'h0100_0000, 32'h0,
                           32'h7FF0_0000)};
    plan = {plan, row_load(4'd1, 16'sh0, 32'h8000_0000, 32'h0, 32'h8000_0000,
                           32'h8000_0000)};
    plan = {plan, row_known(32'h0, 32'h0, 1'b0, 1'b0)};
    plan = {plan, row_load(4'd15, 16'sh8000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0)};
    // More lines requested than exist: all sixteen are summed.
    plan = {plan, row_cfg(REG_OUTPUT_MODE, {30'd0, MODE_SEQ})};
    plan = {plan, row_cfg(REG_ACTIVE_LINES, 32'd31)};
    plan = {plan, row_cfg(REG_GLOBAL_PHASE, 32'hFFFF_FFFF)};
    plan = {plan, row_tick()};
    plan = {plan, row_tick()};
    plan = {plan, row_tick()};
    // The sequential slot must survive a complex-mode tick.
    plan = {plan, row_cfg(REG_OUTPUT_MODE, {30'd0, MODE_COMPLEX})};
    plan = {plan, row_cfg(REG_GLOBAL_PHASE, 32'h4000_0000)};
    plan = {plan, row_tick()};
    plan = {plan, row_cfg(REG_OUTPUT_MODE, {30'd0, MODE_SEQ})};
    plan = {plan, row_tick()};
    // Lines above the active count must hold still.
    plan = {plan, row_cfg(REG_ACTIVE_LINES, 32'd1)};
    plan = {plan, row_tick()};
    plan = {plan, row_cfg(REG_ACTIVE_LINES, 32'd16)};
    plan = {plan, row_tick()};

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[k].reg_idx, plan[k].value);
      end else begin
        send_request(plan[k].req, plan[k].typed, plan[k].known);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p % 5)
        0: lines_pick = 5'd31;
        1: lines_pick = 5'd16;
        2: lines_pick = 5'd0;
        default: lines_pick = 5'($urandom_range(1, 31));
      endcase
      case (p % 4)
        0: gphase_pick = 32'h0;
        1: gphase_pick = 32'hFFFF_FFFF;
        default: gphase_pick = $urandom();
      endcase
      cfg_write(REG_ACTIVE_LINES, {27'd0, lines_pick});
      cfg_write(REG_OUTPUT_MODE, {30'd0, MODE_ORDER[(p / 2) % 4]});
      cfg_write(REG_GLOBAL_PHASE, gphase_pick);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        r = random_load();
        if ($urandom_range(0, 9) < 6) r.func = FUNC_TICK;
        send_request(r, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dssg_pkg.sv
design/dssg_ram.sv
design/dssg_cordic.sv
design/dssg_acc.sv
design/damped_sinusoid_sum_generator_core.sv
tb/sv/testbench.sv
